// ===== src/pot_pkg.sv =====
// ----------------------------------------------------------------------------
// pot_pkg
// Shared widths, codes and reset values for the page occupancy tracker.
// ----------------------------------------------------------------------------
package pot_pkg;

   localparam int ADDR_BITS     = 40;
   localparam int END_BITS      = ADDR_BITS + 1;
   localparam int SHIFT_W       = 5;
   localparam int PMASK_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int BACKED_W      = 13;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 40;

   localparam int DEF_MAX_PAGES = 4096;
   localparam int DEF_WORD_BITS = 32;

   localparam logic [SHIFT_W-1:0]   PAGE_SHIFT_RST  = 5'd16;
   localparam logic [ADDR_BITS-1:0] REGION_SIZE_RST = 40'd268435456;

   localparam logic [CSR_IDX_W-1:0] REG_PAGE_SHIFT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REGION_SIZE = 4'd1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PAST_END  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_START_MIS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_END_MIS   = 2'd3;

endpackage

// ===== src/pot_if.sv =====
// ----------------------------------------------------------------------------
// pot_if
// Valid/ready channels for bind requests and their responses.
// ----------------------------------------------------------------------------
interface pot_req_if import pot_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] start_addr;
   logic [ADDR_BITS-1:0] size_bytes;
   logic                 bind_req;

   modport source (output valid, output start_addr, output size_bytes,
                   output bind_req, input ready);
   modport sink   (input valid, input start_addr, input size_bytes,
                   input bind_req, output ready);
endinterface

interface pot_rsp_if import pot_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BACKED_W-1:0] backed_pages;

   modport source (output valid, output status, output backed_pages, input ready);
   modport sink   (input valid, input status, input backed_pages, output ready);
endinterface

// ===== src/pot_occ_ram.sv =====
// ----------------------------------------------------------------------------
// pot_occ_ram
// Occupancy bitmap storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pot_occ_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pot_word_update.sv =====
// ----------------------------------------------------------------------------
// pot_word_update
// Sets or clears a bit range of one bitmap word and counts flipped bits.
// ----------------------------------------------------------------------------
module pot_word_update #(
   parameter int LB = 5
) (
   input  logic [(1<<LB)-1:0] old_word,
   input  logic [LB-1:0]      lo_bit,
   input  logic [LB-1:0]      hi_bit,
   input  logic               bind_req,
   output logic [(1<<LB)-1:0] new_word,
   output logic [LB:0]        flips
);

   localparam int WIDTH = 1 << LB;
   localparam int BYTES = WIDTH / 8;

   logic [WIDTH-1:0] mask;
   logic [WIDTH-1:0] diff;

   function automatic logic [3:0] pop8(input logic [7:0] b);
      logic [3:0] s;
      s = 4'd0;
      for (int i = 0; i < 8; i++) begin
         s = s + {3'd0, b[i]};
      end
      return s;
   endfunction

   always_comb begin
      for (int i = 0; i < WIDTH; i++) begin
         mask[i] = (LB'(i) >= lo_bit) && (LB'(i) <= hi_bit);
      end
      new_word = bind_req ? (old_word | mask) : (old_word & ~mask);
      diff     = old_word ^ new_word;
   end

   always_comb begin
      flips = '0;
      for (int j = 0; j < BYTES; j++) begin
         flips = flips + (LB+1)'(pop8(diff[j*8 +: 8]));
      end
   end

endmodule

// ===== src/page_occupancy_tracker_top.sv =====
// ----------------------------------------------------------------------------
// page_occupancy_tracker_top
// Page occupancy bitmap with alignment checks and a backed page count.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one bind/unbind request per beat (start, size, bind flag).
//   rsp_ch returns one beat per request: status and the backed page count
//   after the request. csr_* writes page_shift (index 0) and region_size
//   (index 1); write only while no request is in flight.
// Flow: a rejected request or one that marks no page skips the walk and
//   answers straight from the checks. Otherwise the request walks the
//   bitmap RAM one word per cycle, read then modify/write, then folds
//   flips into the count; the next request is taken in the cycle after
//   the response is loaded. The walk covers each word touched in turn.
// Reset: synchronous. The count clears at once; the bitmap RAM is then
//   zeroed one word a cycle, all ceil(MAX_PAGES / word width) words (128 at
//   default settings), with req_ch.ready low meanwhile.
// Stall: the response sits in an output register until taken; a new
//   request may be accepted meanwhile and completes once that register
//   frees up.
// ----------------------------------------------------------------------------
module page_occupancy_tracker_top import pot_pkg::*; #(
   parameter int MAX_PAGES = DEF_MAX_PAGES,
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   pot_req_if.sink               req_ch,
   pot_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LB        = $clog2(WORD_BITS);
   localparam int MEM_BITS  = 1 << LB;
   localparam int OCC_WORDS = (MAX_PAGES + MEM_BITS - 1) / MEM_BITS;
   localparam int ADDR_W    = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int CNT_W     = $clog2(MAX_PAGES + 1);

   localparam logic [END_BITS-1:0] MAX_P    = END_BITS'(MAX_PAGES);
   localparam logic [ADDR_W-1:0]   LAST_W   = ADDR_W'(OCC_WORDS - 1);
   localparam logic [LB-1:0]       TOP_BIT  = LB'(MEM_BITS - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHK0  = 3'd2;
   localparam logic [2:0] S_CHK1  = 3'd3;
   localparam logic [2:0] S_CHK2  = 3'd4;
   localparam logic [2:0] S_WALK  = 3'd5;
   localparam logic [2:0] S_DRAIN = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [SHIFT_W-1:0]    ps_ff, ps_in;
   logic [ADDR_BITS-1:0]  region_ff, region_in;

   logic [ADDR_BITS-1:0]  start_ff, start_in;
   logic [ADDR_BITS-1:0]  size_ff, size_in;
   logic                  bind_ff, bind_in;
   logic [END_BITS-1:0]   end_ff, end_in;
   logic [PMASK_W-1:0]    pmask_ff, pmask_in;
   logic [ADDR_BITS-1:0]  first_ff, first_in;
   logic [ADDR_BITS-1:0]  npages_ff, npages_in;
   logic [END_BITS:0]     end_up_ff, end_up_in;
   logic                  past_ff, past_in;
   logic                  smis_ff, smis_in;
   logic                  emis_ff, emis_in;
   logic [END_BITS-1:0]   last_ff, last_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic [ADDR_W-1:0]     cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]     first_addr_ff, first_addr_in;
   logic [ADDR_W-1:0]     last_addr_ff, last_addr_in;
   logic [LB-1:0]         first_bit_ff, first_bit_in;
   logic [LB-1:0]         last_bit_ff, last_bit_in;

   logic                  mod_v_ff, mod_v_in;
   logic [ADDR_W-1:0]     mod_addr_ff, mod_addr_in;
   logic                  cnt_v_ff, cnt_v_in;
   logic [LB:0]           flips_ff, flips_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [BACKED_W-1:0]   rsp_backed_ff, rsp_backed_in;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [MEM_BITS-1:0]   ram_wr_data;
   logic                  ram_rd_en;
   logic [MEM_BITS-1:0]   ram_rd_data;

   logic [LB-1:0]         upd_lo;
   logic [LB-1:0]         upd_hi;
   logic [MEM_BITS-1:0]   upd_word;
   logic [LB:0]           upd_flips;

   logic [PAGE_W-1:0]     first_pg;
   logic [PAGE_W-1:0]     last_pg;
   logic                  do_walk;

   pot_occ_ram #(
      .WIDTH  (MEM_BITS),
      .DEPTH  (OCC_WORDS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_addr_ff),
      .rd_data (ram_rd_data)
   );

   assign upd_lo = (mod_addr_ff == first_addr_ff) ? first_bit_ff : '0;
   assign upd_hi = (mod_addr_ff == last_addr_ff) ? last_bit_ff : TOP_BIT;

   pot_word_update #(
      .LB (LB)
   ) u_upd (
      .old_word (ram_rd_data),
      .lo_bit   (upd_lo),
      .hi_bit   (upd_hi),
      .bind_req (bind_ff),
      .new_word (upd_word),
      .flips    (upd_flips)
   );

   assign first_pg = PAGE_W'(first_ff);
   assign last_pg  = (last_ff >= MAX_P) ? PAGE_W'(MAX_PAGES - 1) : PAGE_W'(last_ff - 1'b1);
   assign do_walk  = (status_in == ST_OK) && (END_BITS'(first_ff) < last_ff) &&
                     (END_BITS'(first_ff) < MAX_P);

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.backed_pages = rsp_backed_ff;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      ps_in         = ps_ff;
      region_in     = region_ff;
      start_in      = start_ff;
      size_in       = size_ff;
      bind_in       = bind_ff;
      end_in        = end_ff;
      pmask_in      = pmask_ff;
      first_in      = first_ff;
      npages_in     = npages_ff;
      end_up_in     = end_up_ff;
      past_in       = past_ff;
      smis_in       = smis_ff;
      emis_in       = emis_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      cur_addr_in   = cur_addr_ff;
      first_addr_in = first_addr_ff;
      last_addr_in  = last_addr_ff;
      first_bit_in  = first_bit_ff;
      last_bit_in   = last_bit_ff;
      mod_v_in      = 1'b0;
      mod_addr_in   = mod_addr_ff;
      cnt_v_in      = mod_v_ff;
      flips_in      = upd_flips;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_backed_in = rsp_backed_ff;
      ram_wr_en     = mod_v_ff;
      ram_wr_addr   = mod_addr_ff;
      ram_wr_data   = upd_word;
      ram_rd_en     = 1'b0;

      if (cnt_v_ff) begin
         count_in = bind_ff ? count_ff + CNT_W'(flips_ff) : count_ff - CNT_W'(flips_ff);
      end

      // status needs the previous stage's flags in S_CHK2 only
      priority if (past_ff) begin
         status_in = ST_PAST_END;
      end else if (smis_ff) begin
         status_in = ST_START_MIS;
      end else if (emis_ff && (end_up_ff != (END_BITS+1)'(region_ff))) begin
         status_in = ST_END_MIS;
      end else begin
         status_in = ST_OK;
      end
      if (state_ff != S_CHK2) begin
         status_in = status_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            if (clr_addr_ff == LAST_W) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               start_in = req_ch.start_addr;
               size_in  = req_ch.size_bytes;
               bind_in  = req_ch.bind_req;
               state_in = S_CHK0;
            end
         end
         S_CHK0: begin
            end_in    = END_BITS'(start_ff) + END_BITS'(size_ff);
            pmask_in  = (PMASK_W'(1) << ps_ff) - 1'b1;
            first_in  = start_ff >> ps_ff;
            npages_in = size_ff >> ps_ff;
            state_in  = S_CHK1;
         end
         S_CHK1: begin
            end_up_in = ((END_BITS+1)'(end_ff) + (END_BITS+1)'(pmask_ff)) &
                        ~((END_BITS+1)'(pmask_ff));
            past_in   = end_ff > END_BITS'(region_ff);
            smis_in   = (start_ff & ADDR_BITS'(pmask_ff)) != '0;
            emis_in   = (end_ff & END_BITS'(pmask_ff)) != '0;
            last_in   = END_BITS'(first_ff) + END_BITS'(npages_ff);
            state_in  = S_CHK2;
         end
         S_CHK2: begin
            cur_addr_in   = ADDR_W'(first_pg >> LB);
            first_addr_in = ADDR_W'(first_pg >> LB);
            last_addr_in  = ADDR_W'(last_pg >> LB);
            first_bit_in  = first_pg[LB-1:0];
            last_bit_in   = last_pg[LB-1:0];
            state_in      = do_walk ? S_WALK : S_RESP;
         end
         S_WALK: begin
            ram_rd_en   = 1'b1;
            mod_v_in    = 1'b1;
            mod_addr_in = cur_addr_ff;
            if (cur_addr_ff == last_addr_ff) begin
               state_in = S_DRAIN;
            end else begin
               cur_addr_in = cur_addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!mod_v_ff && !cnt_v_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_backed_in = BACKED_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
      endcase

      if (csr_wr_en) begin
         if (csr_index == REG_PAGE_SHIFT) begin
            ps_in = csr_wdata[SHIFT_W-1:0];
         end else if (csr_index == REG_REGION_SIZE) begin
            region_in = csr_wdata[ADDR_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         ps_ff        <= PAGE_SHIFT_RST;
         region_ff    <= REGION_SIZE_RST;
         mod_v_ff     <= 1'b0;
         cnt_v_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         ps_ff        <= ps_in;
         region_ff    <= region_in;
         mod_v_ff     <= mod_v_in;
         cnt_v_ff     <= cnt_v_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      size_ff       <= size_in;
      bind_ff       <= bind_in;
      end_ff        <= end_in;
      pmask_ff      <= pmask_in;
      first_ff      <= first_in;
      npages_ff     <= npages_in;
      end_up_ff     <= end_up_in;
      past_ff       <= past_in;
      smis_ff       <= smis_in;
      emis_ff       <= emis_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      cur_addr_ff   <= cur_addr_in;
      first_addr_ff <= first_addr_in;
      last_addr_ff  <= last_addr_in;
      first_bit_ff  <= first_bit_in;
      last_bit_ff   <= last_bit_in;
      mod_addr_ff   <= mod_addr_in;
      flips_ff      <= flips_in;
      rsp_status_ff <= rsp_status_in;
      rsp_backed_ff <= rsp_backed_in;
   end

endmodule

// ===== src/pot_checker.sv =====
// ----------------------------------------------------------------------------
// pot_checker
// Port-level checks for the page occupancy tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pot_checker import pot_pkg::*; #(
   parameter int MAX_PAGES = DEF_MAX_PAGES
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [BACKED_W-1:0] rsp_backed
);

   logic                seen_ff;
   logic [BACKED_W-1:0] last_bp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= 1'b0;
         last_bp_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff    <= 1'b1;
         last_bp_ff <= rsp_backed;
      end
   end

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_backed))
      else $error("stalled response beat changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_backed) <= 32'(MAX_PAGES)) || (MAX_PAGES >= (1 << BACKED_W)))
      else $error("backed page count above page total");

   // a rejected request leaves the count untouched
   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) && seen_ff |-> rsp_backed == last_bp_ff)
      else $error("rejected request changed the backed page count");

endmodule

bind page_occupancy_tracker_top pot_checker #(
   .MAX_PAGES (MAX_PAGES)
) u_pot_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_backed (rsp_ch.backed_pages)
);
